// File: hw/rtl/ggh_pkg.sv
// shared types, codes and constants of the go-to-goal heading and speed core
// no dependencies
package ggh_pkg;

	localparam int HOLD_START_DEF   = 200;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CNT_W            = 5;
	localparam int HOLD_STEP        = 10;
	localparam int HOLD_FLOOR       = 10;
	localparam int PI_Q13           = 25736;
	localparam int TWO_PI_Q13       = 51472;
	localparam int HALF_PI_Q16      = 102944;
	localparam int INV_GAIN_Q30     = 652032874;
	localparam int DIV_STEPS        = 31;

	typedef enum logic [1:0] {
		KIND_ALL = 2'd0,
		KIND_YAW = 2'd1,
		KIND_X   = 2'd2,
		KIND_Y   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_GOAL_X    = 3'd0,
		REG_GOAL_Y    = 3'd1,
		REG_ALIGN_TOL = 3'd2,
		REG_TURN_SPD  = 3'd3,
		REG_MIN_SPD   = 3'd4,
		REG_ARRIVE    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic             ld_pose;
		logic             diff;
		logic             rot;
		logic             cord_step;
		logic             mul_lo;
		logic             mul_hi;
		logic             sum;
		logic             ang;
		logic             div_init;
		logic             div_step;
		logic             load_out;
		logic [CNT_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} status_t;

	// atan(2^-i) in q.16 radians, rounded to nearest
	function automatic logic [15:0] atan_q16(input logic [CNT_W-1:0] i);
		logic [15:0] r;
		case (i)
			5'd0:    r = 16'd51472;
			5'd1:    r = 16'd30386;
			5'd2:    r = 16'd16055;
			5'd3:    r = 16'd8150;
			5'd4:    r = 16'd4091;
			5'd5:    r = 16'd2047;
			5'd6:    r = 16'd1024;
			5'd7:    r = 16'd512;
			5'd8:    r = 16'd256;
			5'd9:    r = 16'd128;
			5'd10:   r = 16'd64;
			5'd11:   r = 16'd32;
			5'd12:   r = 16'd16;
			5'd13:   r = 16'd8;
			5'd14:   r = 16'd4;
			5'd15:   r = 16'd2;
			5'd16:   r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/ggh_ctrl.sv
// sequencer of the go-to-goal core: steps the datapath through one item
// depends on ggh_pkg
module ggh_ctrl import ggh_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_stall,
	input  status_t st,
	output logic    busy,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIFF, S_ROT, S_CORD, S_MLO, S_MHI, S_SUM, S_ANG, S_DIVI, S_DIV, S_FIN
	} state_t;

	localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             fin_ok;

	assign fin_ok = !st.out_full || !out_stall;
	assign busy   = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DIFF;
				S_DIFF: state_q <= S_ROT;
				S_ROT: begin
					cnt_q   <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CORD_LAST) state_q <= S_MLO;
				end
				S_MLO: state_q <= S_MHI;
				S_MHI: state_q <= S_SUM;
				S_SUM: state_q <= S_ANG;
				S_ANG: state_q <= S_DIVI;
				S_DIVI: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) state_q <= S_FIN;
				end
				S_FIN: if (fin_ok) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.idx       = cnt_q;
		cmd.ld_pose   = (state_q == S_IDLE) && in_valid;
		cmd.diff      = (state_q == S_DIFF);
		cmd.rot       = (state_q == S_ROT);
		cmd.cord_step = (state_q == S_CORD);
		cmd.mul_lo    = (state_q == S_MLO);
		cmd.mul_hi    = (state_q == S_MHI);
		cmd.sum       = (state_q == S_SUM);
		cmd.ang       = (state_q == S_ANG);
		cmd.div_init  = (state_q == S_DIVI);
		cmd.div_step  = (state_q == S_DIV);
		cmd.load_out  = (state_q == S_FIN) && fin_ok;
	end

endmodule

// File: hw/rtl/ggh_dpath.sv
// datapath of the go-to-goal core: pose, cordic, gain multiply, divider
// depends on ggh_pkg
module ggh_dpath import ggh_pkg::*; #(
	parameter int HOLD_START = HOLD_START_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            st,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [1:0]         kind,
	input  logic signed [31:0] new_x,
	input  logic signed [31:0] new_y,
	input  logic signed [15:0] new_yaw,
	input  logic               out_stall,
	output logic               out_valid,
	output logic signed [15:0] heading_error,
	output logic [30:0]        drive_speed
);

	localparam logic [7:0] HOLD_LOAD = 8'(HOLD_START);

	logic signed [31:0] goal_x_q, goal_y_q;
	logic [14:0]        tol_q;
	logic [30:0]        turn_q, min_q, radius_q;
	logic signed [31:0] pose_x_q, pose_y_q;
	logic signed [15:0] pose_yaw_q;
	logic [7:0]         hold_q;

	logic signed [34:0] x_q, y_q;
	logic signed [19:0] z_q;
	logic [63:0]        acc_q, prod_q;
	logic [30:0]        dist_q;
	logic signed [17:0] err_q;
	logic               turn_sel_q;
	logic [7:0]         rem_q;
	logic [30:0]        quo_q;
	logic               out_valid_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= -32'sd655360;
			goal_y_q <= 32'sd655360;
			tol_q    <= 15'd573;
			turn_q   <= 31'd655;
			min_q    <= 31'd19661;
			radius_q <= 31'd6554;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GOAL_X:    goal_x_q <= cfg_data;
				REG_GOAL_Y:    goal_y_q <= cfg_data;
				REG_ALIGN_TOL: tol_q    <= cfg_data[14:0];
				REG_TURN_SPD:  turn_q   <= cfg_data[30:0];
				REG_MIN_SPD:   min_q    <= cfg_data[30:0];
				REG_ARRIVE:    radius_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// saturated goal minus pose
	function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return d[31:0];
	endfunction

	logic signed [34:0] xs, ys;
	logic signed [19:0] at;
	logic signed [16:0] bearing;
	logic signed [17:0] e0, e1, e2, mag_err;
	logic [33:0]        mag;
	logic [30:0]        dist_n;
	logic [8:0]         trial;
	logic [30:0]        spd;

	always_comb begin
		xs      = x_q >>> cmd.idx;
		ys      = y_q >>> cmd.idx;
		at      = 20'(atan_q16(cmd.idx));
		mag     = 34'((acc_q + (prod_q << 17) + 64'd536870912) >> 30);
		dist_n  = (mag > 34'h7fff_ffff) ? 31'h7fff_ffff : mag[30:0];
		bearing = 17'((z_q + 20'sd4) >>> 3);
		e0      = 18'(bearing) - 18'(pose_yaw_q);
		e1      = (e0 < -18'sd25736) ? e0 + 18'sd51472 : e0;
		e2      = (e1 > 18'sd25736) ? e1 - 18'sd51472 : e1;
		mag_err = e2[17] ? -e2 : e2;
		trial   = {rem_q, quo_q[30]};
		if (turn_sel_q) spd = turn_q;
		else spd = (quo_q < min_q) ? min_q : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q   <= '0;
			pose_y_q   <= '0;
			pose_yaw_q <= '0;
			hold_q     <= 8'(HOLD_FLOOR);
		end else begin
			if (cmd.ld_pose) begin
				case (kind)
					KIND_ALL: begin
						pose_x_q   <= new_x;
						pose_y_q   <= new_y;
						pose_yaw_q <= new_yaw;
					end
					KIND_YAW: pose_yaw_q <= new_yaw;
					KIND_X:   pose_x_q   <= new_x;
					default:  pose_y_q   <= new_y;
				endcase
			end
			if (cmd.ang) begin
				if ({1'b0, mag_err} > {4'b0, tol_q}) hold_q <= HOLD_LOAD;
				else if (hold_q < 8'(HOLD_FLOOR + HOLD_STEP)) hold_q <= 8'(HOLD_FLOOR);
				else hold_q <= hold_q - 8'(HOLD_STEP);
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			x_q <= 35'(sat_diff(goal_x_q, pose_x_q));
			y_q <= 35'(sat_diff(goal_y_q, pose_y_q));
			z_q <= '0;
		end
		// left half plane: rotate into the right half first
		if (cmd.rot && x_q < 0) begin
			if (y_q >= 0) begin
				x_q <= y_q;
				y_q <= -x_q;
				z_q <= 20'sd102944;
			end else begin
				x_q <= -y_q;
				y_q <= x_q;
				z_q <= -20'sd102944;
			end
		end
		if (cmd.cord_step) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else if (y_q < 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
		// magnitude times inverse gain, split into two partial products
		if (cmd.mul_lo) prod_q <= 64'(x_q[16:0]) * 64'(INV_GAIN_Q30);
		if (cmd.mul_hi) begin
			acc_q  <= prod_q;
			prod_q <= 64'(x_q[32:17]) * 64'(INV_GAIN_Q30);
		end
		if (cmd.sum) dist_q <= dist_n;
		if (cmd.ang) begin
			err_q      <= e2;
			turn_sel_q <= ({1'b0, mag_err} > {4'b0, tol_q});
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= dist_q;
		end
		// restoring divide, one quotient bit per step
		if (cmd.div_step) begin
			if (trial >= {1'b0, hold_q}) begin
				rem_q <= 8'(trial - {1'b0, hold_q});
				quo_q <= {quo_q[29:0], 1'b1};
			end else begin
				rem_q <= trial[7:0];
				quo_q <= {quo_q[29:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			if (dist_q < radius_q) begin
				heading_error <= '0;
				drive_speed   <= '0;
			end else begin
				heading_error <= err_q[15:0];
				drive_speed   <= spd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	assign out_valid   = out_valid_q;
	assign st.out_full = out_valid_q;

endmodule

// File: hw/rtl/go_to_goal_heading_speed_core.sv
// top level of the go-to-goal heading and speed core
// depends on ggh_pkg, ggh_ctrl, ggh_dpath
//
// usage:
// - input channel (in_valid / in_stall) carries one pose beat: kind selects
//   which of new_x, new_y, new_yaw update the stored pose
// - output channel (out_valid / out_stall) returns one beat per input beat:
//   heading_error (q3.13) and drive_speed (q15.16)
// - config port: cfg_we with cfg_index and cfg_data writes one register;
//   the user must write only while the core is idle, the core does not enforce it
// - an input beat passes through the pose difference, half-plane rotation,
//   one cordic step per cycle, two gain partial products, then a restoring
//   divider before it reaches the output beat
// - in_stall is high while an item is in work; the next beat is taken
//   the cycle after the result is loaded into the output register
// - if the receiver stalls, the result waits in the output register; a new
//   item can still be computed, it only waits at the final load
// - reset puts pose at zero, hold count at ten and registers at their
//   defaults; no output beat is pending after reset
module go_to_goal_heading_speed_core import ggh_pkg::*; #(
	parameter int HOLD_START   = HOLD_START_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic signed [31:0] new_x,
	input  logic signed [31:0] new_y,
	input  logic signed [15:0] new_yaw,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] heading_error,
	output logic [30:0]        drive_speed,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	cmd_t    cmd;
	status_t st;
	logic    busy;

	// sequencer
	ggh_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_stall(out_stall),
		.st       (st),
		.busy     (busy),
		.cmd      (cmd)
	);

	// arithmetic, pose state and output register
	ggh_dpath #(
		.HOLD_START(HOLD_START)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.new_x        (new_x),
		.new_y        (new_y),
		.new_yaw      (new_yaw),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.heading_error(heading_error),
		.drive_speed  (drive_speed)
	);

	// a beat is taken only in idle
	assign in_stall = busy;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core not busy after input beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(heading_error) && $stable(drive_speed))
		else $error("stalled output beat changed");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output beat without an item in work");
`endif

endmodule

// File: test/tb.sv
// testbench of the go-to-goal heading and speed core: directed and random pose beats
// checked against a bit-accurate controller model held in a small scoreboard class
// depends on ggh_pkg and go_to_goal_heading_speed_core
`timescale 1ns / 100ps

module tb;
	import ggh_pkg::*;

	localparam int LATENCY   = 64;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 730;

	// pose controller model plus queue of expected steering beats
	class steer_board;
		logic signed [31:0] goal_x, goal_y, pos_x, pos_y;
		logic [14:0]        tol;
		logic [30:0]        turn_spd, min_spd, arrive;
		logic signed [15:0] yaw;
		int unsigned        hold;
		logic signed [15:0] q_err[$];
		logic [30:0]        q_spd[$];
		int                 fails;

		function void clear();
			goal_x = -655360; goal_y = 655360; tol = 573; turn_spd = 655;
			min_spd = 19661; arrive = 6554; pos_x = 0; pos_y = 0; yaw = 0;
			hold = 10; fails = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] d);
			case (idx)
				REG_GOAL_X:    goal_x = d;
				REG_GOAL_Y:    goal_y = d;
				REG_ALIGN_TOL: tol = d[14:0];
				REG_TURN_SPD:  turn_spd = d[30:0];
				REG_MIN_SPD:   min_spd = d[30:0];
				REG_ARRIVE:    arrive = d[30:0];
				default: ;
			endcase
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint atan_tab(int i);
			case (i)
				0: return 51472;  1: return 30386; 2: return 16055; 3: return 8150;
				4: return 4091;   5: return 2047;  6: return 1024;  7: return 512;
				8: return 256;    9: return 128;   10: return 64;   11: return 32;
				12: return 16;    13: return 8;    14: return 4;    15: return 2;
				16: return 1;
				default: return 0;
			endcase
		endfunction

		// pose update, cordic bearing and distance, hold-count speed law
		function void note_pose(kind_t k, logic signed [31:0] nx, logic signed [31:0] ny,
				logic signed [15:0] nyaw);
			longint x, y, z, t, xs, ys, bear, err, mag_err;
			longint unsigned mag, spd;
			case (k)
				KIND_ALL: begin
					pos_x = nx; pos_y = ny; yaw = nyaw;
				end
				KIND_YAW: yaw = nyaw;
				KIND_X:   pos_x = nx;
				default:  pos_y = ny;
			endcase
			x = clip32(longint'(goal_x) - longint'(pos_x));
			y = clip32(longint'(goal_y) - longint'(pos_y));
			z = 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = HALF_PI_Q16;
				end else begin
					t = x; x = -y; y = t; z = -HALF_PI_Q16;
				end
			end
			for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x += ys; y -= xs; z += atan_tab(i);
				end else if (y < 0) begin
					x -= ys; y += xs; z -= atan_tab(i);
				end
			end
			bear = (z + 4) >>> 3;
			mag = ($unsigned(x) * INV_GAIN_Q30 + (64'd1 << 29)) >> 30;
			if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
			err = bear - longint'(yaw);
			if (err < -PI_Q13) err += TWO_PI_Q13;
			if (err > PI_Q13) err -= TWO_PI_Q13;
			mag_err = err < 0 ? -err : err;
			if (mag_err > longint'(tol)) begin
				spd = turn_spd;
				hold = HOLD_START_DEF;
			end else begin
				if (hold < HOLD_FLOOR + HOLD_STEP) hold = HOLD_FLOOR;
				else hold -= HOLD_STEP;
				spd = mag / hold;
				if (spd < min_spd) spd = min_spd;
			end
			if (mag < arrive) begin
				spd = 0; err = 0;
			end
			q_err.push_back(err[15:0]);
			q_spd.push_back(spd[30:0]);
		endfunction

		function void check_beat(logic signed [15:0] got_err, logic [30:0] got_spd);
			if (q_err.size() == 0) begin
				report("output beat with nothing expected");
				return;
			end
			if (got_err !== q_err[0])
				report($sformatf("heading_error got %0d want %0d", got_err, q_err[0]));
			if (got_spd !== q_spd[0])
				report($sformatf("drive_speed got %0d want %0d", got_spd, q_spd[0]));
			void'(q_err.pop_front());
			void'(q_spd.pop_front());
		endfunction

		function void report(string msg);
			fails++;
			if (fails <= 40) $display("mismatch at %0t: %s", $time, msg);
		endfunction
	endclass

	logic               clk, arst_n;
	logic               in_valid, in_stall, out_valid, out_stall, cfg_we;
	logic [1:0]         kind;
	logic signed [31:0] new_x, new_y;
	logic signed [15:0] new_yaw;
	logic signed [15:0] heading_error;
	logic [30:0]        drive_speed;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               calm;
	int                 idle_cycles;
	steer_board         sb;

	go_to_goal_heading_speed_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .new_x(new_x), .new_y(new_y), .new_yaw(new_yaw),
		.out_valid(out_valid), .out_stall(out_stall),
		.heading_error(heading_error), .drive_speed(drive_speed),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// output sampling and watchdog on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_beat(heading_error, drive_speed);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_MAX) begin
				$display("watchdog expired");
				$display("tb failed");
				$finish;
			end
		end
	end

	// receiver stalls in bursts, none once calm
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 9);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_cfg(reg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, d);
	endtask

	// send one pose beat, possibly after an idle burst
	task automatic send_pose(kind_t k, logic [31:0] x, logic [31:0] y, logic [15:0] yw);
		if (!calm && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 9)) @(negedge clk);
		@(negedge clk);
		kind <= k;
		new_x <= x;
		new_y <= y;
		new_yaw <= yw;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_pose(k, x, y, yw);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.q_err.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_yaw();
		return 16'($signed($urandom_range(0, 2 * PI_Q13)) - PI_Q13);
	endfunction

	// mostly small coordinates near the origin, sometimes full range
	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 3))
			0:       return $urandom();
			1:       return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
			default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	task automatic random_phase(int n);
		kind_t k;
		logic [31:0] x, y;
		for (int i = 0; i < n; i++) begin
			k = kind_t'($urandom_range(0, 3));
			x = rand_pos();
			y = rand_pos();
			// sometimes land right at the goal to exercise arrival
			if ($urandom_range(0, 7) == 0) begin
				x = sb.goal_x + $signed($urandom_range(0, 200)) - 100;
				y = sb.goal_y + $signed($urandom_range(0, 200)) - 100;
			end
			send_pose(k, x, y, rand_yaw());
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		calm = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_ALL;
		new_x = '0;
		new_y = '0;
		new_yaw = '0;
		cfg_we = 1'b0;
		cfg_index = REG_GOAL_X;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: default goal, every kind, field extremes, yaw beyond pi
		send_pose(KIND_ALL, 0, 0, 0);
		send_pose(KIND_ALL, 32'h7FFFFFFF, 32'h80000000, 16'sh7FFF);
		send_pose(KIND_ALL, 32'h80000000, 32'h7FFFFFFF, 16'sh8000);
		send_pose(KIND_YAW, 0, 0, 16'(PI_Q13));
		send_pose(KIND_YAW, 0, 0, 16'(-PI_Q13));
		send_pose(KIND_X, -655360, 0, 0);
		send_pose(KIND_Y, 0, 655360, 0);
		send_pose(KIND_X, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		send_pose(KIND_ALL, 0, 0, 16'd2356);
		for (int i = 0; i < 6; i++) send_pose(KIND_YAW, 0, 0, 16'd2356);
		send_pose(KIND_ALL, -655360, 655360, 0);
		send_pose(KIND_ALL, 100, -100, 0);

		// hold-off until idle, then extreme settings
		drain();
		write_cfg(REG_GOAL_X, 32'h7FFFFFFF);
		write_cfg(REG_GOAL_Y, 32'h80000000);
		write_cfg(REG_ALIGN_TOL, 32'd25736);
		write_cfg(REG_TURN_SPD, 32'h7FFFFFFF);
		write_cfg(REG_MIN_SPD, 32'd0);
		write_cfg(REG_ARRIVE, 32'd0);
		send_pose(KIND_ALL, 32'h7FFFFFFF, 32'h80000000, 0);
		send_pose(KIND_ALL, 32'h80000000, 32'h7FFFFFFF, 16'sh7FFF);
		random_phase(N_RANDOM / 5);

		drain();
		write_cfg(REG_GOAL_X, 0);
		write_cfg(REG_GOAL_Y, 0);
		write_cfg(REG_ALIGN_TOL, 0);
		write_cfg(REG_TURN_SPD, 0);
		write_cfg(REG_MIN_SPD, 32'h7FFFFFFF);
		write_cfg(REG_ARRIVE, 32'h7FFFFFFF);
		random_phase(N_RANDOM / 10);

		// several random settings
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_cfg(REG_GOAL_X, rand_pos());
			write_cfg(REG_GOAL_Y, rand_pos());
			write_cfg(REG_ALIGN_TOL, $urandom_range(0, 25736));
			write_cfg(REG_TURN_SPD, $urandom_range(0, 1 << 20));
			write_cfg(REG_MIN_SPD, $urandom_range(0, 1 << 16));
			write_cfg(REG_ARRIVE, $urandom_range(0, 1 << 18));
			if (ph == 3) calm = 1'b1;
			random_phase(N_RANDOM * 7 / 40);
		end

		drain();
		if (sb.fails == 0 && sb.q_err.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/ggh_pkg.sv
hw/rtl/ggh_ctrl.sv
hw/rtl/ggh_dpath.sv
hw/rtl/go_to_goal_heading_speed_core.sv
test/tb.sv
